FILE: sv/srpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_pkg
// Shared types and constants for the sequence range progression engine.
// ----------------------------------------------------------------------------
package srpe_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 11;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_OVERWRITE = 3'd2,
        OP_READ      = 3'd3,
        OP_ADD       = 3'd4,
        OP_ASSIGN    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  rend;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] intercept;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  length;
        logic              error;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

endpackage

FILE: sv/srpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srpe_ram (
    input  logic                             clk,
    input  srpe_pkg::mem_wr_t                wr,
    input  logic [srpe_pkg::ADDR_W-1:0]      raddr,
    output logic [srpe_pkg::DATA_W-1:0]      rdata
);

    logic [srpe_pkg::DATA_W-1:0] mem [srpe_pkg::CAPACITY];
    logic [srpe_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/srpe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_seq
// Request sequencer: range check, then one element per cycle through the
// store (read, update in the shared adder, write back in the next cycle).
// ----------------------------------------------------------------------------
module srpe_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  srpe_pkg::req_t              req,
    input  logic                        out_free,
    output logic                        idle,
    output logic                        done,
    output srpe_pkg::res_t              res,
    output srpe_pkg::mem_wr_t           mem_wr,
    output logic [srpe_pkg::ADDR_W-1:0] mem_raddr,
    input  logic [srpe_pkg::DATA_W-1:0] mem_rdata
);

    localparam int CNT_W  = srpe_pkg::CNT_W;
    localparam int ADDR_W = srpe_pkg::ADDR_W;
    localparam int DATA_W = srpe_pkg::DATA_W;

    srpe_pkg::state_t state_reg, state_next;
    srpe_pkg::req_t   req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  last_reg, last_next;
    logic [DATA_W-1:0] term_reg, term_next;
    logic [DATA_W-1:0] pend_term_reg, pend_term_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              err_reg, err_next;

    logic              chk_err;
    logic              chk_empty;
    logic [CNT_W-1:0]  chk_start;
    logic [CNT_W-1:0]  chk_last;
    logic [CNT_W-1:0]  pos_c;
    logic [CNT_W-1:0]  rend_c;
    logic [CNT_W-1:0]  tgt_c;
    logic [DATA_W-1:0] wdata;
    logic              wb_en;

    assign pos_c  = CNT_W'(req_reg.pos);
    assign rend_c = CNT_W'(req_reg.rend);

    // bounds check and sweep limits
    always_comb
    begin
        chk_err   = 1'b0;
        chk_empty = 1'b0;
        chk_start = pos_c;
        chk_last  = pos_c;
        unique case (req_reg.op)
            srpe_pkg::OP_INSERT:
            begin
                chk_err   = (pos_c > count_reg) ||
                            (count_reg >= CNT_W'(srpe_pkg::CAPACITY));
                chk_empty = (pos_c == count_reg);
                chk_start = count_reg - CNT_W'(1);
                chk_last  = pos_c;
            end
            srpe_pkg::OP_DELETE:
            begin
                chk_err   = (pos_c >= count_reg);
                chk_empty = (pos_c + CNT_W'(1) == count_reg);
                chk_start = pos_c + CNT_W'(1);
                chk_last  = count_reg - CNT_W'(1);
            end
            srpe_pkg::OP_OVERWRITE:
            begin
                chk_err   = (pos_c >= count_reg);
                chk_empty = 1'b1;
            end
            srpe_pkg::OP_READ:
            begin
                chk_err   = (pos_c >= count_reg);
            end
            srpe_pkg::OP_ADD, srpe_pkg::OP_ASSIGN:
            begin
                chk_err   = !((pos_c < rend_c) && (rend_c <= count_reg));
                chk_last  = rend_c - CNT_W'(1);
            end
            default:
            begin
                chk_err   = 1'b1;
            end
        endcase
    end

    // write-back address for the element read this cycle
    always_comb
    begin
        unique case (req_reg.op)
            srpe_pkg::OP_INSERT: tgt_c = idx_reg + CNT_W'(1);
            srpe_pkg::OP_DELETE: tgt_c = idx_reg - CNT_W'(1);
            default:             tgt_c = idx_reg;
        endcase
    end

    // shared update unit
    always_comb
    begin
        unique case (req_reg.op)
            srpe_pkg::OP_ADD:    wdata = mem_rdata + pend_term_reg;
            srpe_pkg::OP_ASSIGN: wdata = pend_term_reg;
            default:             wdata = mem_rdata;
        endcase
    end

    assign wb_en = pend_valid_reg && (req_reg.op != srpe_pkg::OP_READ);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srpe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = srpe_pkg::ST_CHECK;
                end
            end
            srpe_pkg::ST_CHECK:
            begin
                if (chk_err)
                begin
                    state_next = srpe_pkg::ST_DONE;
                end
                else if (chk_empty)
                begin
                    state_next = srpe_pkg::ST_FINAL;
                end
                else
                begin
                    state_next = srpe_pkg::ST_SWEEP;
                end
            end
            srpe_pkg::ST_SWEEP:
            begin
                if (idx_reg == last_reg)
                begin
                    state_next = srpe_pkg::ST_DRAIN;
                end
            end
            srpe_pkg::ST_DRAIN:
            begin
                state_next = srpe_pkg::ST_FINAL;
            end
            srpe_pkg::ST_FINAL:
            begin
                state_next = srpe_pkg::ST_DONE;
            end
            srpe_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = srpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srpe_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next        = req_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        term_next       = term_reg;
        pend_term_next  = pend_term_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        rd_next         = rd_reg;
        err_next        = err_reg;
        mem_wr.en       = 1'b0;
        mem_wr.addr     = pend_addr_reg;
        mem_wr.data     = wdata;
        mem_raddr       = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            srpe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                end
            end
            srpe_pkg::ST_CHECK:
            begin
                term_next = req_reg.intercept;
                rd_next   = '0;
                err_next  = chk_err;
                idx_next  = chk_start;
                last_next = chk_last;
            end
            srpe_pkg::ST_SWEEP:
            begin
                mem_wr.en       = wb_en;
                pend_valid_next = 1'b1;
                pend_addr_next  = tgt_c[ADDR_W-1:0];
                pend_term_next  = term_reg;
                term_next       = term_reg + req_reg.slope;
                if (req_reg.op == srpe_pkg::OP_INSERT)
                begin
                    idx_next = idx_reg - CNT_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            srpe_pkg::ST_DRAIN:
            begin
                mem_wr.en = wb_en;
                if (req_reg.op == srpe_pkg::OP_READ)
                begin
                    rd_next = mem_rdata;
                end
            end
            srpe_pkg::ST_FINAL:
            begin
                mem_wr.addr = req_reg.pos[ADDR_W-1:0];
                mem_wr.data = req_reg.value;
                if (req_reg.op == srpe_pkg::OP_INSERT)
                begin
                    mem_wr.en  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else if (req_reg.op == srpe_pkg::OP_OVERWRITE)
                begin
                    mem_wr.en = 1'b1;
                end
                else if (req_reg.op == srpe_pkg::OP_DELETE)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            srpe_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign idle           = (state_reg == srpe_pkg::ST_IDLE);
    assign done           = (state_reg == srpe_pkg::ST_DONE) && out_free;
    assign res.read_value = rd_reg;
    assign res.length     = count_reg;
    assign res.error      = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srpe_pkg::ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        term_reg      <= term_next;
        pend_term_reg <= pend_term_next;
        pend_addr_reg <= pend_addr_next;
        rd_reg        <= rd_next;
        err_reg       <= err_next;
    end

endmodule

FILE: sv/sequence_range_progression_engine.sv
`timescale 1ns / 1ps
// Requests sweep the elements they touch through the store (shift length, range
// width, one for read); an overwrite or a shift-free insert or delete sweeps none,
// and a rejected request goes straight to its result beat.
// The engine takes one request at a time; the sweep moves one element per cycle
// through the element store and shared adder.
// Reset clears the element count and control; store contents stay undefined.
// ----------------------------------------------------------------------------
// sequence_range_progression_engine
// Ordered sequence store with insert, delete, overwrite, read and range
// arithmetic-progression add/assign. Registered result beat on the output.
// ----------------------------------------------------------------------------
module sequence_range_progression_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  operation,
    input  logic [10:0]                 position,
    input  logic [10:0]                 range_end,
    input  logic signed [31:0]          element_value,
    input  logic signed [31:0]          slope,
    input  logic signed [31:0]          intercept,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          read_value,
    output logic [10:0]                 length,
    output logic                        error
);

    srpe_pkg::req_t                req;
    srpe_pkg::res_t                res;
    srpe_pkg::mem_wr_t             mem_wr;
    logic [srpe_pkg::ADDR_W-1:0]   mem_raddr;
    logic [srpe_pkg::DATA_W-1:0]   mem_rdata;
    logic                          seq_idle;
    logic                          seq_done;
    logic                          out_free;
    logic                          out_valid_reg, out_valid_next;
    srpe_pkg::res_t                out_res_reg, out_res_next;

    assign req.op        = operation;
    assign req.pos       = position;
    assign req.rend      = range_end;
    assign req.value     = element_value;
    assign req.slope     = slope;
    assign req.intercept = intercept;

    assign in_ready = seq_idle;
    assign out_free = !out_valid_reg || out_ready;

    srpe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && seq_idle),
        .req       (req),
        .out_free  (out_free),
        .idle      (seq_idle),
        .done      (seq_done),
        .res       (res),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    srpe_ram u_ram (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (seq_done)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_res_reg.read_value;
    assign length     = out_res_reg.length;
    assign error      = out_res_reg.error;

endmodule
